// ----- sv/mlfq_schedule_simulator_assert.svh -----
`ifndef MLFQ_SCHEDULE_SIMULATOR_ASSERT_SVH
`define MLFQ_SCHEDULE_SIMULATOR_ASSERT_SVH

// Checks a condition at every clock edge out of reset.
`define MLFQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition implies another in the next cycle.
`define MLFQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- sv/mlfq_pkg.sv -----
package mlfq_pkg;

  localparam int ARR_W    = 16;
  localparam int Q_W      = 16;
  localparam int ID_W     = 5;
  localparam int COMP_W   = 21;
  localparam int SUM_W    = 25;
  localparam int LVL_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_Q0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Q1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Q2 = 2'd2;

  localparam logic [Q_W-1:0] Q0_RESET = 16'd2;
  localparam logic [Q_W-1:0] Q1_RESET = 16'd4;
  localparam logic [Q_W-1:0] Q2_RESET = 16'd8;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ORD_FILL,
    S_SI_RD,
    S_SI_WAIT,
    S_SI_ARR,
    S_SJ_RD,
    S_SJ_WAIT,
    S_SJ_CMP,
    S_SI_WR,
    S_SIM_INIT,
    S_SEL,
    S_POP_WAIT,
    S_RUN_CMP,
    S_CLK_ADD,
    S_PUSH,
    S_TAT,
    S_TSUM,
    S_WCALC,
    S_WSUM,
    S_ADM_RD,
    S_ADM_WAIT,
    S_ADM_CHK,
    S_MIN_RD,
    S_MIN_CHK,
    S_OUT_RD,
    S_OUT_WAIT,
    S_OUT_TAT,
    S_OUT_W,
    S_OUT_HOLD,
    S_TOT,
    S_TOT_HOLD
  } state_t;

endpackage

// ----- sv/mlfq_if.sv -----
interface mlfq_in_if;
  logic                     valid;
  logic                     ready;
  logic [mlfq_pkg::ARR_W-1:0] arrival_time;
  logic [mlfq_pkg::ARR_W-1:0] burst_time;
  logic                     last_job;

  modport source (output valid, arrival_time, burst_time, last_job, input ready);
  modport sink   (input valid, arrival_time, burst_time, last_job, output ready);
endinterface

interface mlfq_out_if;
  logic                      valid;
  logic                      ready;
  logic [mlfq_pkg::ID_W-1:0]   job_id;
  logic [mlfq_pkg::COMP_W-1:0] completion_time;
  logic [mlfq_pkg::SUM_W-1:0]  turnaround_time;
  logic [mlfq_pkg::SUM_W-1:0]  wait_time;
  logic                      last_record;

  modport source (output valid, job_id, completion_time, turnaround_time, wait_time,
                  last_record, input ready);
  modport sink   (input valid, job_id, completion_time, turnaround_time, wait_time,
                  last_record, output ready);
endinterface

// ----- sv/mlfq_schedule_simulator.sv -----
// channel  | dir | payload
// in_if    | in  | arrival_time, burst_time, last_job
// out_if   | out | job_id, completion_time, turnaround_time, wait_time, last_record
// cfg_*    | in  | quantum_level0..2, written by index
//
// Ready stays high while loading, and a job request is taken whenever valid.
// The last job request starts a run: index fill, exchange sort, then the
// simulation, whose slice lengths, clock and time sums go through the single
// add/subtract unit, with an admission scan over all jobs after each slice.
// Results leave one at a time, each held until out_if takes it.
// Input is held off from the last job until the totals record is taken.
// Reset is synchronous; job memories are not cleared, only control state, counts, sums and quanta.
`include "mlfq_schedule_simulator_assert.svh"

module mlfq_schedule_simulator #(
  parameter int MAX_PROCS = 16,
  parameter int LEVELS    = 3,
  parameter int TIME_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mlfq_in_if.sink                        in_if,
  mlfq_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlfq_pkg::CFG_W-1:0]     cfg_data
);
  import mlfq_pkg::*;

  localparam int DW      = (TIME_BITS < ARR_W) ? TIME_BITS : ARR_W;
  localparam int IDX_W   = $clog2(MAX_PROCS);
  localparam int CNT_W   = $clog2(MAX_PROCS + 1);
  localparam int CLK_W   = DW + $clog2(MAX_PROCS) + 1;
  localparam int AW      = (CLK_W > SUM_W) ? CLK_W : SUM_W;
  localparam int RDEPTH  = LEVELS * MAX_PROCS;
  localparam int RA_W    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

  function automatic logic [RA_W-1:0] ring_addr(input logic [LVL_W-1:0] l,
                                                input logic [IDX_W-1:0] idx);
    ring_addr = RA_W'(l) * RA_W'(MAX_PROCS) + RA_W'(idx);
  endfunction

  // memories
  logic [DW-1:0]    arr_mem [MAX_PROCS];
  logic [DW-1:0]    bur_mem [MAX_PROCS];
  logic [DW-1:0]    rem_mem [MAX_PROCS];
  logic [CLK_W-1:0] fin_mem [MAX_PROCS];
  logic [IDX_W-1:0] ord_mem [MAX_PROCS];
  logic [IDX_W-1:0] ring_mem [RDEPTH];

  logic [DW-1:0]    arr_q, bur_q, rem_q;
  logic [CLK_W-1:0] fin_q;
  logic [IDX_W-1:0] ord_q, ring_q;

  logic [IDX_W-1:0] rec_raddr, rec_waddr, ord_raddr, ord_waddr, ord_wdata;
  logic             arr_we, bur_we, rem_we, fin_we, ord_we, ring_we;
  logic [DW-1:0]    rem_wdata;
  logic [CLK_W-1:0] fin_wdata;
  logic [RA_W-1:0]  ring_raddr, ring_waddr;
  logic [IDX_W-1:0] ring_wdata;

  // control and datapath registers
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] loaded_r, loaded_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] done_r, done_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [IDX_W-1:0] slot_i_r, slot_i_nxt, slot_j_r, slot_j_nxt;
  logic [DW-1:0]    arr_i_r, arr_i_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [DW-1:0]    run_r, run_nxt, rem_r, rem_nxt;
  logic [DW-1:0]    arr_r, arr_nxt, bur_r, bur_nxt, next_r, next_nxt;
  logic [AW-1:0]    tat_r, tat_nxt, w_r, w_nxt;
  logic [AW-1:0]    tsum_r, tsum_nxt, wsum_r, wsum_nxt;
  logic [CLK_W-1:0] clock_r, clock_nxt;
  logic             added_r, added_nxt, idle_mode_r, idle_mode_nxt, found_r, found_nxt;
  logic [IDX_W-1:0] head_r [LEVELS];
  logic [IDX_W-1:0] head_nxt [LEVELS];
  logic [CNT_W-1:0] cnt_r [LEVELS];
  logic [CNT_W-1:0] cnt_nxt [LEVELS];
  logic [MAX_PROCS-1:0] adm_r, adm_nxt;
  logic [Q_W-1:0]   q_r [3];

  logic             out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [COMP_W-1:0] out_comp_r, out_comp_nxt;
  logic [SUM_W-1:0] out_tat_r, out_tat_nxt, out_wait_r, out_wait_nxt;
  logic             out_last_r, out_last_nxt;

  // shared unit
  alu_op_t          alu_op;
  logic [AW-1:0]    alu_a, alu_b, alu_res;
  logic             alu_lt;

  mlfq_alu #(.W(AW)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .lt  (alu_lt)
  );

  logic             in_ready;
  logic             in_acc, out_acc;
  logic [CNT_W-1:0] last_idx;
  logic             sel_found;
  logic [LVL_W-1:0] sel_lvl;
  logic [Q_W-1:0]   q_sel, q_eff;
  logic             push_en;
  logic [LVL_W-1:0] push_lvl;
  logic [IDX_W-1:0] push_slot;
  logic [CNT_W:0]   pos_sum;
  logic [IDX_W-1:0] push_pos;
  logic [2:0]       lvl_up;
  logic             take;
  logic [AW-1:0]    id_ext;

  assign in_ready     = (state_r == S_IDLE);
  assign in_if.ready  = in_ready;
  assign in_acc       = in_if.valid && in_ready;
  assign out_acc      = out_valid_r && out_if.ready;
  assign last_idx     = n_r - CNT_W'(1);

  assign out_if.valid           = out_valid_r;
  assign out_if.job_id          = out_id_r;
  assign out_if.completion_time = out_comp_r;
  assign out_if.turnaround_time = out_tat_r;
  assign out_if.wait_time       = out_wait_r;
  assign out_if.last_record     = out_last_r;

  always_comb begin
    sel_found = 1'b0;
    sel_lvl   = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        sel_found = 1'b1;
        sel_lvl   = LVL_W'(l);
      end
    end
  end

  always_comb begin
    case (lvl_r)
      2'd0:    q_sel = q_r[0];
      2'd1:    q_sel = q_r[1];
      default: q_sel = q_r[2];
    endcase
    q_eff = (q_sel == '0) ? Q_W'(1) : q_sel;
  end

  assign lvl_up   = {1'b0, lvl_r} + 3'd1;
  assign pos_sum  = (CNT_W+1)'(head_r[push_lvl]) + (CNT_W+1)'(cnt_r[push_lvl]);
  assign push_pos = (pos_sum >= (CNT_W+1)'(MAX_PROCS)) ?
                    IDX_W'(pos_sum - (CNT_W+1)'(MAX_PROCS)) : IDX_W'(pos_sum);
  assign id_ext   = AW'(slot_i_r) + AW'(1);

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    n_nxt         = n_r;
    done_nxt      = done_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    slot_i_nxt    = slot_i_r;
    slot_j_nxt    = slot_j_r;
    arr_i_nxt     = arr_i_r;
    lvl_nxt       = lvl_r;
    run_nxt       = run_r;
    rem_nxt       = rem_r;
    arr_nxt       = arr_r;
    bur_nxt       = bur_r;
    next_nxt      = next_r;
    tat_nxt       = tat_r;
    w_nxt         = w_r;
    tsum_nxt      = tsum_r;
    wsum_nxt      = wsum_r;
    clock_nxt     = clock_r;
    added_nxt     = added_r;
    idle_mode_nxt = idle_mode_r;
    found_nxt     = found_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    adm_nxt       = adm_r;
    out_valid_nxt = out_valid_r;
    out_id_nxt    = out_id_r;
    out_comp_nxt  = out_comp_r;
    out_tat_nxt   = out_tat_r;
    out_wait_nxt  = out_wait_r;
    out_last_nxt  = out_last_r;

    rec_raddr  = slot_i_r;
    rec_waddr  = slot_i_r;
    arr_we     = 1'b0;
    bur_we     = 1'b0;
    rem_we     = 1'b0;
    fin_we     = 1'b0;
    rem_wdata  = rem_r;
    fin_wdata  = clock_r;
    ord_raddr  = i_r;
    ord_we     = 1'b0;
    ord_waddr  = i_r;
    ord_wdata  = slot_i_r;
    ring_raddr = ring_addr(sel_lvl, head_r[sel_lvl]);
    ring_we    = 1'b0;
    ring_waddr = '0;
    ring_wdata = '0;
    push_en    = 1'b0;
    push_lvl   = lvl_r;
    push_slot  = slot_i_r;
    take       = 1'b0;

    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (loaded_r < CNT_W'(MAX_PROCS)) begin
            rec_waddr  = IDX_W'(loaded_r);
            arr_we     = 1'b1;
            bur_we     = 1'b1;
            rem_we     = 1'b1;
            rem_wdata  = in_if.burst_time[DW-1:0];
            loaded_nxt = loaded_r + CNT_W'(1);
          end
          if (in_if.last_job) begin
            n_nxt     = (loaded_r < CNT_W'(MAX_PROCS)) ? loaded_r + CNT_W'(1) : loaded_r;
            i_nxt     = '0;
            state_nxt = S_ORD_FILL;
          end
        end
      end

      S_ORD_FILL: begin
        ord_we    = 1'b1;
        ord_waddr = i_r;
        ord_wdata = i_r;
        if (CNT_W'(i_r) == last_idx) begin
          i_nxt     = '0;
          state_nxt = (n_r == CNT_W'(1)) ? S_SIM_INIT : S_SI_RD;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end

      S_SI_RD: begin
        ord_raddr = i_r;
        state_nxt = S_SI_WAIT;
      end

      S_SI_WAIT: begin
        slot_i_nxt = ord_q;
        rec_raddr  = ord_q;
        j_nxt      = i_r + IDX_W'(1);
        state_nxt  = S_SI_ARR;
      end

      S_SI_ARR: begin
        arr_i_nxt = arr_q;
        state_nxt = S_SJ_RD;
      end

      S_SJ_RD: begin
        ord_raddr = j_r;
        state_nxt = S_SJ_WAIT;
      end

      S_SJ_WAIT: begin
        slot_j_nxt = ord_q;
        rec_raddr  = ord_q;
        state_nxt  = S_SJ_CMP;
      end

      S_SJ_CMP: begin
        // position i lives in slot_i/arr_i until the inner pass ends
        alu_op = ALU_SUB;
        alu_a  = AW'(arr_q);
        alu_b  = AW'(arr_i_r);
        if (alu_lt) begin
          ord_we     = 1'b1;
          ord_waddr  = j_r;
          ord_wdata  = slot_i_r;
          slot_i_nxt = slot_j_r;
          arr_i_nxt  = arr_q;
        end
        if (CNT_W'(j_r) == last_idx) begin
          state_nxt = S_SI_WR;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_SJ_RD;
        end
      end

      S_SI_WR: begin
        ord_we    = 1'b1;
        ord_waddr = i_r;
        ord_wdata = slot_i_r;
        if (CNT_W'(i_r) + CNT_W'(2) == n_r) begin
          state_nxt = S_SIM_INIT;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_SI_RD;
        end
      end

      S_SIM_INIT: begin
        for (int l = 0; l < LEVELS; l++) begin
          head_nxt[l] = '0;
          cnt_nxt[l]  = '0;
        end
        adm_nxt   = '0;
        clock_nxt = '0;
        tsum_nxt  = '0;
        wsum_nxt  = '0;
        done_nxt  = '0;
        state_nxt = S_SEL;
      end

      S_SEL: begin
        if (done_r == n_r) begin
          i_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else if (sel_found) begin
          lvl_nxt           = sel_lvl;
          head_nxt[sel_lvl] = (head_r[sel_lvl] == IDX_W'(MAX_PROCS - 1)) ?
                              '0 : head_r[sel_lvl] + IDX_W'(1);
          cnt_nxt[sel_lvl]  = cnt_r[sel_lvl] - CNT_W'(1);
          state_nxt         = S_POP_WAIT;
        end else begin
          idle_mode_nxt = 1'b1;
          added_nxt     = 1'b0;
          j_nxt         = '0;
          state_nxt     = S_ADM_RD;
        end
      end

      S_POP_WAIT: begin
        slot_i_nxt = ring_q;
        rec_raddr  = ring_q;
        state_nxt  = S_RUN_CMP;
      end

      S_RUN_CMP: begin
        // one subtract gives both the slice length and the new remainder
        alu_op  = ALU_SUB;
        alu_a   = AW'(rem_q);
        alu_b   = AW'(q_eff);
        arr_nxt = arr_q;
        bur_nxt = bur_q;
        if (alu_lt) begin
          run_nxt = rem_q;
          rem_nxt = '0;
        end else begin
          run_nxt = DW'(q_eff);
          rem_nxt = alu_res[DW-1:0];
        end
        state_nxt = S_CLK_ADD;
      end

      S_CLK_ADD: begin
        alu_op    = ALU_ADD;
        alu_a     = AW'(clock_r);
        alu_b     = AW'(run_r);
        clock_nxt = alu_res[CLK_W-1:0];
        rem_we    = 1'b1;
        state_nxt = (rem_r == '0) ? S_TAT : S_PUSH;
      end

      S_PUSH: begin
        push_en       = 1'b1;
        push_lvl      = (lvl_up < 3'(LEVELS)) ? lvl_up[LVL_W-1:0] : lvl_r;
        push_slot     = slot_i_r;
        idle_mode_nxt = 1'b0;
        added_nxt     = 1'b0;
        j_nxt         = '0;
        state_nxt     = S_ADM_RD;
      end

      S_TAT: begin
        alu_op    = ALU_SUB;
        alu_a     = AW'(clock_r);
        alu_b     = AW'(arr_r);
        tat_nxt   = alu_res;
        fin_we    = 1'b1;
        done_nxt  = done_r + CNT_W'(1);
        state_nxt = S_TSUM;
      end

      S_TSUM: begin
        alu_op    = ALU_ADD;
        alu_a     = tsum_r;
        alu_b     = tat_r;
        tsum_nxt  = alu_res;
        state_nxt = S_WCALC;
      end

      S_WCALC: begin
        alu_op    = ALU_SUB;
        alu_a     = tat_r;
        alu_b     = AW'(bur_r);
        w_nxt     = alu_res;
        state_nxt = S_WSUM;
      end

      S_WSUM: begin
        alu_op        = ALU_ADD;
        alu_a         = wsum_r;
        alu_b         = w_r;
        wsum_nxt      = alu_res;
        idle_mode_nxt = 1'b0;
        added_nxt     = 1'b0;
        j_nxt         = '0;
        state_nxt     = S_ADM_RD;
      end

      S_ADM_RD: begin
        ord_raddr = j_r;
        state_nxt = S_ADM_WAIT;
      end

      S_ADM_WAIT: begin
        slot_j_nxt = ord_q;
        rec_raddr  = ord_q;
        state_nxt  = S_ADM_CHK;
      end

      S_ADM_CHK: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(clock_r);
        alu_b  = AW'(arr_q);
        take   = !alu_lt && !adm_r[slot_j_r];
        if (take) begin
          push_en           = 1'b1;
          push_lvl          = '0;
          push_slot         = slot_j_r;
          adm_nxt[slot_j_r] = 1'b1;
          added_nxt         = 1'b1;
        end
        if (CNT_W'(j_r) == last_idx) begin
          j_nxt = '0;
          if (idle_mode_r && !(added_r || take)) begin
            found_nxt = 1'b0;
            state_nxt = S_MIN_RD;
          end else begin
            state_nxt = S_SEL;
          end
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_ADM_RD;
        end
      end

      S_MIN_RD: begin
        rec_raddr = j_r;
        state_nxt = S_MIN_CHK;
      end

      S_MIN_CHK: begin
        // nothing due: jump the clock to the earliest pending arrival
        alu_op = ALU_SUB;
        alu_a  = AW'(arr_q);
        alu_b  = AW'(next_r);
        take   = !adm_r[j_r] && (!found_r || alu_lt);
        if (take) begin
          next_nxt  = arr_q;
          found_nxt = 1'b1;
        end
        if (CNT_W'(j_r) == last_idx) begin
          if (!(found_r || take)) begin
            i_nxt     = '0;
            state_nxt = S_OUT_RD;
          end else begin
            clock_nxt = CLK_W'(take ? arr_q : next_r);
            state_nxt = S_SEL;
          end
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_MIN_RD;
        end
      end

      S_OUT_RD: begin
        ord_raddr = i_r;
        state_nxt = S_OUT_WAIT;
      end

      S_OUT_WAIT: begin
        slot_i_nxt = ord_q;
        rec_raddr  = ord_q;
        state_nxt  = S_OUT_TAT;
      end

      S_OUT_TAT: begin
        alu_op    = ALU_SUB;
        alu_a     = AW'(fin_q);
        alu_b     = AW'(arr_q);
        tat_nxt   = alu_res;
        bur_nxt   = bur_q;
        clock_nxt = fin_q;
        state_nxt = S_OUT_W;
      end

      S_OUT_W: begin
        alu_op        = ALU_SUB;
        alu_a         = tat_r;
        alu_b         = AW'(bur_r);
        out_valid_nxt = 1'b1;
        out_id_nxt    = id_ext[ID_W-1:0];
        out_comp_nxt  = COMP_W'(AW'(clock_r));
        out_tat_nxt   = tat_r[SUM_W-1:0];
        out_wait_nxt  = alu_res[SUM_W-1:0];
        out_last_nxt  = 1'b0;
        state_nxt     = S_OUT_HOLD;
      end

      S_OUT_HOLD: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (CNT_W'(i_r) == last_idx) begin
            state_nxt = S_TOT;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end

      S_TOT: begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = '0;
        out_comp_nxt  = '0;
        out_tat_nxt   = tsum_r[SUM_W-1:0];
        out_wait_nxt  = wsum_r[SUM_W-1:0];
        out_last_nxt  = 1'b1;
        state_nxt     = S_TOT_HOLD;
      end

      S_TOT_HOLD: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          loaded_nxt    = '0;
          adm_nxt       = '0;
          clock_nxt     = '0;
          tsum_nxt      = '0;
          wsum_nxt      = '0;
          for (int l = 0; l < LEVELS; l++) begin
            head_nxt[l] = '0;
            cnt_nxt[l]  = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (push_en && (cnt_r[push_lvl] < CNT_W'(MAX_PROCS))) begin
      ring_we           = 1'b1;
      ring_waddr        = ring_addr(push_lvl, push_pos);
      ring_wdata        = push_slot;
      cnt_nxt[push_lvl] = cnt_r[push_lvl] + CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      n_r         <= '0;
      done_r      <= '0;
      clock_r     <= '0;
      tsum_r      <= '0;
      wsum_r      <= '0;
      adm_r       <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
      q_r[0] <= Q0_RESET;
      q_r[1] <= Q1_RESET;
      q_r[2] <= Q2_RESET;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      n_r         <= n_nxt;
      done_r      <= done_nxt;
      clock_r     <= clock_nxt;
      tsum_r      <= tsum_nxt;
      wsum_r      <= wsum_nxt;
      adm_r       <= adm_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_Q0:  q_r[0] <= cfg_data;
          CFG_Q1:  q_r[1] <= cfg_data;
          CFG_Q2:  q_r[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    slot_i_r    <= slot_i_nxt;
    slot_j_r    <= slot_j_nxt;
    arr_i_r     <= arr_i_nxt;
    lvl_r       <= lvl_nxt;
    run_r       <= run_nxt;
    rem_r       <= rem_nxt;
    arr_r       <= arr_nxt;
    bur_r       <= bur_nxt;
    next_r      <= next_nxt;
    tat_r       <= tat_nxt;
    w_r         <= w_nxt;
    added_r     <= added_nxt;
    idle_mode_r <= idle_mode_nxt;
    found_r     <= found_nxt;
    out_id_r    <= out_id_nxt;
    out_comp_r  <= out_comp_nxt;
    out_tat_r   <= out_tat_nxt;
    out_wait_r  <= out_wait_nxt;
    out_last_r  <= out_last_nxt;
  end

  // job record memories
  always_ff @(posedge clk) begin
    if (arr_we) arr_mem[rec_waddr] <= in_if.arrival_time[DW-1:0];
    if (bur_we) bur_mem[rec_waddr] <= in_if.burst_time[DW-1:0];
    if (rem_we) rem_mem[rec_waddr] <= rem_wdata;
    if (fin_we) fin_mem[rec_waddr] <= fin_wdata;
    arr_q <= arr_mem[rec_raddr];
    bur_q <= bur_mem[rec_raddr];
    rem_q <= rem_mem[rec_raddr];
    fin_q <= fin_mem[rec_raddr];
  end

  // sorted order
  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_q <= ord_mem[ord_raddr];
  end

  // level rings
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    ring_q <= ring_mem[ring_raddr];
  end

  `MLFQ_ASSERT_ALWAYS(a_no_load_during_out, !(in_ready && out_valid_r),
    "input ready while a result is pending")
  `MLFQ_ASSERT_NEXT(a_totals_ends_run, out_acc && out_last_r, in_ready && loaded_r == '0,
    "block not back to loading after totals record")
  `MLFQ_ASSERT_ALWAYS(a_done_bound, state_r != S_SEL || done_r <= n_r,
    "more jobs completed than loaded")
  `MLFQ_ASSERT_ALWAYS(a_loaded_cap, loaded_r <= CNT_W'(MAX_PROCS),
    "loaded count beyond capacity")

endmodule

// ----- sv/mlfq_alu.sv -----
module mlfq_alu #(
  parameter int W = 25
) (
  input  mlfq_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      res,
  output logic              lt
);
  import mlfq_pkg::*;

  logic [W:0] diff;

  assign diff = {1'b0, a} - {1'b0, b};
  assign lt   = diff[W];

  always_comb begin
    case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = diff[W-1:0];
      default: res = '0;
    endcase
  end
endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import mlfq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NJOBS = 16;

  typedef struct {
    logic [ARR_W-1:0] arrival;
    logic [ARR_W-1:0] burst;
    logic             last;
  } job_req_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [COMP_W-1:0] finish;
    logic [SUM_W-1:0]  tat;
    logic [SUM_W-1:0]  wt;
    logic              last;
  } sched_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_Q0;
  logic [CFG_W-1:0] cfg_data = '0;

  mlfq_in_if  in_if();
  mlfq_out_if out_if();

  mlfq_schedule_simulator dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  job_req_t   job_q[$];
  sched_rec_t sched_q[$];
  int src_idle = 37, snk_idle = 79;
  int errors = 0, recs_seen = 0, sets_done = 0, jobs_sent = 0;
  logic in_taken = 1'b0;

  // scheduler shadow state
  int unsigned quantum[3] = '{2, 4, 8};
  longint ld_arr[NJOBS], ld_bur[NJOBS], rem[NJOBS], fin[NJOBS];
  int ld_cnt = 0;
  int ord[NJOBS];
  bit admitted[NJOBS];
  int lvl_q[3][$];
  longint sim_clock;

  function automatic int admit_due();
    int added = 0;
    for (int j = 0; j < ld_cnt; j++) begin
      if (!admitted[ord[j]] && ld_arr[ord[j]] <= sim_clock) begin
        lvl_q[0].push_back(ord[j]);
        admitted[ord[j]] = 1'b1;
        added++;
      end
    end
    return added;
  endfunction

  function automatic void schedule_set();
    int done = 0, lvl, s, t;
    longint q, run, nxt, tat, tsum = 0, wsum = 0;
    sched_rec_t r;
    for (int i = 0; i < ld_cnt; i++) begin
      ord[i] = i;
      admitted[i] = 1'b0;
      rem[i] = ld_bur[i];
    end
    // exchange sort, not stable
    for (int i = 0; i + 1 < ld_cnt; i++)
      for (int j = i + 1; j < ld_cnt; j++)
        if (ld_arr[ord[i]] > ld_arr[ord[j]]) begin
          t = ord[i]; ord[i] = ord[j]; ord[j] = t;
        end
    for (int l = 0; l < 3; l++) lvl_q[l].delete();
    sim_clock = 0;
    while (done < ld_cnt) begin
      lvl = 3;
      for (int l = 2; l >= 0; l--) if (lvl_q[l].size() != 0) lvl = l;
      if (lvl == 3) begin
        if (admit_due() == 0) begin
          nxt = -1;
          for (int j = 0; j < ld_cnt; j++)
            if (!admitted[j] && (nxt < 0 || ld_arr[j] < nxt)) nxt = ld_arr[j];
          if (nxt < 0) break;
          sim_clock = nxt;
        end
        continue;
      end
      s = lvl_q[lvl].pop_front();
      q = (quantum[lvl] == 0) ? 1 : quantum[lvl];
      run = (rem[s] < q) ? rem[s] : q;
      rem[s] -= run;
      sim_clock += run;
      if (rem[s] == 0) begin
        fin[s] = sim_clock;
        tsum += sim_clock - ld_arr[s];
        wsum += sim_clock - ld_arr[s] - ld_bur[s];
        done++;
      end else begin
        lvl_q[(lvl < 2) ? lvl + 1 : lvl].push_back(s);
      end
      void'(admit_due());
    end
    for (int k = 0; k < ld_cnt; k++) begin
      s = ord[k];
      tat = fin[s] - ld_arr[s];
      r.id = ID_W'(s + 1);
      r.finish = COMP_W'(fin[s]);
      r.tat = SUM_W'(tat);
      r.wt = SUM_W'(tat - ld_bur[s]);
      r.last = 1'b0;
      sched_q.push_back(r);
    end
    r.id = '0; r.finish = '0; r.tat = SUM_W'(tsum); r.wt = SUM_W'(wsum); r.last = 1'b1;
    sched_q.push_back(r);
    ld_cnt = 0;
    sets_done++;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.arrival_time <= '0;
      in_if.burst_time <= '0;
      in_if.last_job <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (job_q.size() > 0 && $urandom_range(99) >= src_idle) begin
        job_req_t j;
        j = job_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.arrival_time <= j.arrival;
        in_if.burst_time <= j.burst;
        in_if.last_job <= j.last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= snk_idle);
  end

  // accept side: predict
  always @(posedge clk) begin
    in_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      jobs_sent++;
      if (ld_cnt < NJOBS) begin
        ld_arr[ld_cnt] = in_if.arrival_time;
        ld_bur[ld_cnt] = in_if.burst_time;
        ld_cnt++;
      end
      if (in_if.last_job) schedule_set();
    end
  end

  // result side: check
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sched_rec_t e;
      recs_seen++;
      if (sched_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected record id=%0d", out_if.job_id);
      end else begin
        e = sched_q.pop_front();
        if (out_if.job_id !== e.id || out_if.completion_time !== e.finish ||
            out_if.turnaround_time !== e.tat || out_if.wait_time !== e.wt ||
            out_if.last_record !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp id=%0d fin=%0d tat=%0d wt=%0d last=%0b / got %0d %0d %0d %0d %0b",
                     e.id, e.finish, e.tat, e.wt, e.last, out_if.job_id,
                     out_if.completion_time, out_if.turnaround_time, out_if.wait_time,
                     out_if.last_record);
        end
      end
    end
  end

  task automatic add_job(int a, int b, bit l);
    job_req_t j;
    j.arrival = ARR_W'(a); j.burst = ARR_W'(b); j.last = l;
    job_q.push_back(j);
  endtask

  task automatic set_quantum(logic [CFG_IDX_W-1:0] idx, int unsigned v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(v);
    quantum[idx] = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (job_q.size() != 0 || in_if.valid || sched_q.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic random_sets(int want);
    int cnt = 0, n;
    while (cnt < want) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      for (int k = 0; k < n; k++)
        add_job(($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(60),
                (quantum[2] >= 1024 && $urandom_range(9) == 0) ? $urandom_range(65535)
                                                               : $urandom_range(30),
                k == n - 1);
      cnt += n;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults: ties, zero burst, idle gap, lone late job, overflow set
    add_job(5, 3, 0); add_job(0, 0, 0); add_job(5, 7, 0); add_job(0, 1, 0);
    add_job(100, 2, 1);
    add_job(65535, 1, 1);
    for (int k = 0; k < 17; k++) add_job(k * 3, k % 5, k == 16);
    drain();

    set_quantum(CFG_Q0, 1); set_quantum(CFG_Q1, 1); set_quantum(CFG_Q2, 1);
    random_sets(22);
    drain();

    src_idle = 79; snk_idle = 37;
    set_quantum(CFG_Q0, 65535); set_quantum(CFG_Q1, 65535); set_quantum(CFG_Q2, 65535);
    add_job(0, 65535, 0); add_job(65535, 65535, 1);
    random_sets(22);
    drain();

    set_quantum(CFG_Q0, 3); set_quantum(CFG_Q1, 5); set_quantum(CFG_Q2, 65535);
    random_sets(22);
    drain();

    src_idle = 0; snk_idle = 0;
    set_quantum(CFG_Q0, 1); set_quantum(CFG_Q1, 2); set_quantum(CFG_Q2, 3);
    random_sets(22);
    drain();

    set_quantum(CFG_Q0, $urandom_range(1, 65535));
    set_quantum(CFG_Q1, $urandom_range(1, 65535));
    set_quantum(CFG_Q2, $urandom_range(1, 65535));
    random_sets(22);
    drain();

    $display("covered %0d job requests in %0d job sets, %0d records checked, %0d mismatches",
             jobs_sent, sets_done, recs_seen, errors);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout with %0d records outstanding", sched_q.size());
    $display("== FAIL ==");
    $finish;
  end
endmodule
